FILE: sv/adaptive_kickstart_motor_duty_top_defines.svh
//------------------------------------------------------------------------------
// Assertion macros for the adaptive kick-start motor duty block
// Clocked on clk, disabled while rst_n is low.
//------------------------------------------------------------------------------
`ifndef ADAPTIVE_KICKSTART_MOTOR_DUTY_TOP_DEFINES_SVH
`define ADAPTIVE_KICKSTART_MOTOR_DUTY_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define AKMD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("akmd assertion failed (same cycle)");

// consequent must hold in the cycle after the antecedent
`define AKMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("akmd assertion failed (next cycle)");

`endif

FILE: sv/akmd_pkg.sv
//------------------------------------------------------------------------------
// akmd_pkg
// Types, constants and Q0.16 helpers for the adaptive kick-start duty block.
//------------------------------------------------------------------------------
package akmd_pkg;

    localparam int INTERVAL_W = 19;
    localparam int DUTY_W     = 16;
    localparam int COUNT_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    typedef enum logic [2:0] {
        DEC_KICK     = 3'd0,
        DEC_RECOVER  = 3'd1,
        DEC_TOO_SLOW = 3'd2,
        DEC_TOO_FAST = 3'd3,
        DEC_ON_TGT   = 3'd4
    } decision_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET   = 2'd0,
        CFG_MIN_DUTY = 2'd1,
        CFG_MAX_DUTY = 2'd2
    } cfg_index_t;

    // Q1.16 multipliers, round(c * 65536)
    localparam logic [16:0] MUL_KICK_UP    = 17'd65864;  // 1.005
    localparam logic [16:0] MUL_KICK_DOWN  = 17'd64881;  // 0.99
    localparam logic [16:0] MUL_BOOST      = 17'd66191;  // 1.01
    localparam logic [16:0] MUL_STALL_DOWN = 17'd65529;  // 0.9999

    localparam logic [DUTY_W-1:0]     KICK_RESET   = 16'd39322;
    localparam logic [DUTY_W-1:0]     STALL_RESET  = 16'd32768;
    localparam logic [DUTY_W-1:0]     MIN_RESET    = 16'd655;
    localparam logic [DUTY_W-1:0]     MAX_RESET    = 16'd45875;
    localparam logic [INTERVAL_W-1:0] TARGET_RESET = 19'd100000;

    // (x * m + 0.5) >> 16, result fits 17 bits
    function automatic logic [16:0] q16_scale(input logic [15:0] x, input logic [16:0] m);
        logic [33:0] prod;
        prod = 34'(x) * 34'(m) + 34'd32768;
        return prod[32:16];
    endfunction

    function automatic logic [15:0] sat16(input logic [16:0] x);
        return x[16] ? 16'hFFFF : x[15:0];
    endfunction

endpackage

FILE: sv/adaptive_kickstart_motor_duty_top.sv
//------------------------------------------------------------------------------
// adaptive_kickstart_motor_duty_top
// Per-revolution duty controller with adaptive kick and stall levels.
//------------------------------------------------------------------------------
// One input word arrives per motor revolution with the measured interval, the
// stall flag and the duty that was applied. The block answers each word with
// exactly one output word: the next PWM compare value, the decision taken
// (kick, post-stall recovery, too slow, too fast, on target) and the adaptive
// stall level after the update. It is a three-register pipeline: input
// register, decision/state register (where the kick level, stall level and
// previous stall/duty are updated), and output register holding the scaled
// PWM count. A new word is accepted every clock cycle while the output is not
// back-pressured; each word passes the input and decision registers and is
// then held valid in the output register until it is taken. The rate is set
// by the state loop, which closes through the Q0.16 scalers and the clamp.
// Back-pressure on the output side stalls the stages one at a time, so empty
// stages keep filling. Configuration registers are written through a simple
// write port and are meant to be changed only while the pipeline is empty.
`include "adaptive_kickstart_motor_duty_top_defines.svh"

module adaptive_kickstart_motor_duty_top #(
    parameter int PWM_FULL_SCALE = 4095,
    parameter int INTERVAL_BITS  = 19
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [akmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [akmd_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,  // interval_us 18:0, applied_duty_q16 34:19
    input  logic                            s_tuser,  // stalled
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // duty_count 11:0, stall_level_q16 27:12
    output logic [2:0]                      m_tuser   // decision
);
    import akmd_pkg::*;

    localparam int CMP_BITS = (INTERVAL_BITS < INTERVAL_W) ? INTERVAL_BITS : INTERVAL_W;

    // configuration
    logic [INTERVAL_W-1:0] target_reg;
    logic [DUTY_W-1:0]     min_duty_reg;
    logic [DUTY_W-1:0]     max_duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RESET;
            min_duty_reg <= MIN_RESET;
            max_duty_reg <= MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TARGET:   target_reg   <= cfg_data;
                CFG_MIN_DUTY: min_duty_reg <= cfg_data[DUTY_W-1:0];
                CFG_MAX_DUTY: max_duty_reg <= cfg_data[DUTY_W-1:0];
                default:      ;  // unmapped index, ignored
            endcase
        end
    end

    // pipeline handshake: each stage loads when it is empty or draining
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic ready_a, ready_b, ready_c;
    logic s_fire, a_fire, b_fire;

    assign ready_c  = !c_valid_reg || m_tready;
    assign ready_b  = !b_valid_reg || ready_c;
    assign ready_a  = !a_valid_reg || ready_b;
    assign s_tready = ready_a;
    assign s_fire   = s_tvalid && ready_a;
    assign a_fire   = a_valid_reg && ready_b;
    assign b_fire   = b_valid_reg && ready_c;

    // stage A: input register
    logic [INTERVAL_W-1:0] a_interval_reg;
    logic                  a_stalled_reg;
    logic [DUTY_W-1:0]     a_applied_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (ready_a)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_interval_reg <= s_tdata[INTERVAL_W-1:0];
            a_applied_reg  <= s_tdata[INTERVAL_W+DUTY_W-1:INTERVAL_W];
            a_stalled_reg  <= s_tuser;
        end
    end

    // adaptive state
    logic [DUTY_W-1:0] kick_reg, kick_next;
    logic [DUTY_W-1:0] stall_reg, stall_next;
    logic              prev_stalled_reg;
    logic [DUTY_W-1:0] prev_duty_reg;

    logic [DUTY_W-1:0] kick_up, kick_down, stall_down;
    logic [16:0]       boost;
    logic [16:0]       duty_raw;
    logic [DUTY_W-1:0] duty_clamped;
    decision_t         decision_next;
    logic [CMP_BITS-1:0] interval_cmp, target_cmp;

    assign kick_up      = sat16(q16_scale(kick_reg, MUL_KICK_UP));
    assign kick_down    = sat16(q16_scale(kick_reg, MUL_KICK_DOWN));
    assign stall_down   = sat16(q16_scale(stall_reg, MUL_STALL_DOWN));
    assign boost        = q16_scale(stall_reg, MUL_BOOST);
    assign interval_cmp = a_interval_reg[CMP_BITS-1:0];
    assign target_cmp   = target_reg[CMP_BITS-1:0];

    always_comb
    begin
        kick_next  = kick_reg;
        stall_next = stall_reg;
        if (a_stalled_reg)
        begin
            decision_next = DEC_KICK;
            duty_raw      = {1'b0, kick_reg};
            kick_next     = kick_up;
            // remember the last running duty as the new stall floor
            if (!prev_stalled_reg && (prev_duty_reg > stall_reg))
                stall_next = prev_duty_reg;
        end
        else if (prev_stalled_reg)
        begin
            decision_next = DEC_RECOVER;
            duty_raw      = boost;
            kick_next     = kick_down;
        end
        else if (interval_cmp > target_cmp)
        begin
            decision_next = DEC_TOO_SLOW;
            duty_raw      = boost;
        end
        else if (interval_cmp < target_cmp)
        begin
            decision_next = DEC_TOO_FAST;
            duty_raw      = boost;
            stall_next    = stall_down;
        end
        else
        begin
            decision_next = DEC_ON_TGT;
            duty_raw      = {1'b0, a_applied_reg};
        end

        // when the limits cross, values below min get min and all others get max
        if (duty_raw < {1'b0, min_duty_reg})
            duty_clamped = min_duty_reg;
        else if (duty_raw > {1'b0, max_duty_reg})
            duty_clamped = max_duty_reg;
        else
            duty_clamped = duty_raw[DUTY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_reg         <= KICK_RESET;
            stall_reg        <= STALL_RESET;
            prev_stalled_reg <= 1'b1;
            prev_duty_reg    <= '0;
        end
        else if (a_fire)
        begin
            kick_reg         <= kick_next;
            stall_reg        <= stall_next;
            prev_stalled_reg <= a_stalled_reg;
            prev_duty_reg    <= a_applied_reg;
        end
    end

    // stage B: decision register
    logic [DUTY_W-1:0] b_duty_reg;
    decision_t         b_decision_reg;
    logic [DUTY_W-1:0] b_stall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (ready_b)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_duty_reg     <= duty_clamped;
            b_decision_reg <= decision_next;
            b_stall_reg    <= stall_next;
        end
    end

    // stage C: scale to PWM counts, output register
    logic [31:0]        count_prod;
    logic [COUNT_W-1:0] c_count_reg;
    decision_t          c_decision_reg;
    logic [DUTY_W-1:0]  c_stall_reg;

    assign count_prod = {16'd0, b_duty_reg} * 32'(PWM_FULL_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (ready_c)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            c_count_reg    <= count_prod[DUTY_W+COUNT_W-1:DUTY_W];
            c_decision_reg <= b_decision_reg;
            c_stall_reg    <= b_stall_reg;
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {4'd0, c_stall_reg, c_count_reg};
    assign m_tuser  = c_decision_reg;

    // checks
    `AKMD_ASSERT_SAME(a_full_when_blocked, !s_tready,
        a_valid_reg && b_valid_reg && c_valid_reg)
    `AKMD_ASSERT_NEXT(a_kick_never_drops, a_fire && a_stalled_reg,
        kick_reg >= $past(kick_reg))
    `AKMD_ASSERT_NEXT(a_stall_level_held,
        a_fire && decision_next != DEC_TOO_FAST && decision_next != DEC_KICK,
        stall_reg == $past(stall_reg))
    `AKMD_ASSERT_NEXT(a_duty_in_limits, a_fire && min_duty_reg <= max_duty_reg,
        b_duty_reg >= $past(min_duty_reg) && b_duty_reg <= $past(max_duty_reg))

endmodule
